// ===== hdl/sobel_x_convolution_stream_unit_defines.svh =====
// Assertion macros for the checker file of the Sobel-x stream unit.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef SOBEL_X_CONVOLUTION_STREAM_UNIT_DEFINES_SVH
`define SOBEL_X_CONVOLUTION_STREAM_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SXC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SXC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sxc_pkg.sv =====
// Shared constants, codes and types of the Sobel-x stream unit.
// No dependencies; imported by every module of the block except sxc_ram.
`timescale 1ns / 1ps

package sxc_pkg;

  // Line and frame limits
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int KSize     = 3;

  // Field and counter widths
  localparam int PixW     = 8;
  localparam int CfgW     = 11;
  localparam int RowW     = 11;
  localparam int GradW    = 11;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int EffW     = (ColW + 1 > CfgW) ? ColW + 1 : CfgW;
  localparam int CountW   = $clog2(MaxWidth * MaxHeight);
  localparam int AreaW    = CountW + 1;
  localparam int LineW    = 2 * PixW;
  localparam int InDataW  = ((PixW + 7) / 8) * 8;
  localparam int OutDataW = ((GradW + 7) / 8) * 8;
  localparam int CfgIdxW  = 1;

  // Reset values of the configuration registers
  localparam logic [CfgW-1:0] ImageWidthRst  = CfgW'(1024);
  localparam logic [CfgW-1:0] ImageHeightRst = CfgW'(1024);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegImageWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegImageHeight = CfgIdxW'(1);

  // Input command codes
  localparam logic CmdPixel = 1'b0;
  localparam logic CmdDrain = 1'b1;

  // Request handed from the counter stage to the window stage
  typedef struct packed {
    logic [ColW-1:0] col;
    logic [PixW-1:0] pix;
    logic            has_top;
    logic            has_mid;
    logic            col_first;
    logic            emit;
    logic            frame_end;
  } sxc_item_t;

  // Result handed from the window stage to the output buffer
  typedef struct packed {
    logic [GradW-1:0] grad;
    logic             last;
  } sxc_res_t;

endpackage

// ===== hdl/sxc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sxc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Read-first: a read of the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/sxc_ctrl.sv =====
// Front stage: configuration registers, raster counters and line-RAM read.
// Depends on sxc_pkg.
`timescale 1ns / 1ps

module sxc_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sxc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sxc_pkg::CfgW-1:0]     cfg_wdata_i,
  input  logic                         accept_i,
  input  logic                         command_i,
  input  logic [sxc_pkg::PixW-1:0]     pixel_i,
  output logic [sxc_pkg::ColW-1:0]     rd_addr_o,
  output sxc_pkg::sxc_item_t           item_o
);
  import sxc_pkg::*;

  logic [CfgW-1:0]      width_q, height_q;
  logic [AreaW-1:0]     area_d;
  logic [ColW-1:0]      col_q, col_d;
  logic [RowW-1:0]      row_q, row_d;
  logic [CountW-1:0]    cnt_q, cnt_d;
  logic [EffW-1:0]      eff_w, col_inc;
  logic [CfgW-1:0]      eff_h;
  logic [EffW+CfgW-1:0] prod;
  logic [AreaW-1:0]     cnt_inc;
  logic                 col_last, emit, last;

  // Clamp the registers into their working range
  always_comb begin
    if (width_q == '0) begin
      eff_w = EffW'(1);
    end else if (EffW'(width_q) > EffW'(MaxWidth)) begin
      eff_w = EffW'(MaxWidth);
    end else begin
      eff_w = EffW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = CfgW'(1);
    end else if (height_q > CfgW'(MaxHeight)) begin
      eff_h = CfgW'(MaxHeight);
    end else begin
      eff_h = height_q;
    end
    prod   = eff_w * eff_h;
    area_d = prod[AreaW-1:0];
  end

  // Position decode for the incoming request
  always_comb begin
    col_inc  = EffW'(col_q) + EffW'(1);
    col_last = (col_inc >= eff_w);
    cnt_inc  = AreaW'(cnt_q) + AreaW'(1);
    emit     = (row_q >= RowW'(2)) || ((row_q == RowW'(1)) && (col_q != '0));
    last     = emit && (cnt_inc >= area_d);

    item_o.col       = col_q;
    item_o.pix       = ((command_i == CmdPixel) && (row_q < eff_h)) ? pixel_i : '0;
    item_o.has_top   = (row_q >= RowW'(2));
    item_o.has_mid   = (row_q != '0);
    item_o.col_first = (col_q == '0);
    item_o.emit      = emit;
    item_o.frame_end = last;
    rd_addr_o        = col_q;
  end

  // Counter update; a frame end restarts all three counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    cnt_d = cnt_q;
    if (accept_i) begin
      if (last) begin
        col_d = '0;
        row_d = '0;
        cnt_d = '0;
      end else begin
        col_d = col_last ? '0 : col_inc[ColW-1:0];
        row_d = col_last ? row_q + RowW'(1) : row_q;
        cnt_d = emit ? cnt_inc[CountW-1:0] : cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ImageWidthRst;
      height_q <= ImageHeightRst;
      col_q    <= '0;
      row_q    <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegImageWidth:  width_q  <= cfg_wdata_i;
          RegImageHeight: height_q <= cfg_wdata_i;
        endcase
      end
      col_q  <= col_d;
      row_q  <= row_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== hdl/sxc_win.sv =====
// Window stage: line-RAM read-modify-write with forwarding, 3x3 window, gradient.
// Depends on sxc_pkg.
`timescale 1ns / 1ps

module sxc_win (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  sxc_pkg::sxc_item_t        item_i,
  input  logic                      out_ready_i,
  output logic                      adv_o,
  input  logic [sxc_pkg::LineW-1:0] rdata_i,
  output logic                      we_o,
  output logic [sxc_pkg::ColW-1:0]  waddr_o,
  output logic [sxc_pkg::LineW-1:0] wdata_o,
  output logic                      push_o,
  output sxc_pkg::sxc_res_t         res_o
);
  import sxc_pkg::*;

  sxc_item_t               s1_q;
  logic                    s1_vld_q;
  logic                    proc;
  logic                    fw_vld_q;
  logic [ColW-1:0]         fw_addr_q;
  logic [LineW-1:0]        fw_data_q;
  logic [LineW-1:0]        line;
  logic [PixW-1:0]         newc [KSize];
  logic [PixW-1:0]         c1_q [KSize];
  logic [PixW-1:0]         c2_q [KSize];
  logic signed [GradW-1:0] diff [KSize];
  logic signed [GradW-1:0] grad;

  // The stage moves on unless a result is waiting for a full output buffer
  assign adv_o = !s1_vld_q || !s1_q.emit || out_ready_i;
  assign proc  = s1_vld_q && adv_o;

  // Latest write wins over a read that raced it
  always_comb begin
    line = (fw_vld_q && (fw_addr_q == s1_q.col)) ? fw_data_q : rdata_i;
    newc[0] = s1_q.has_top ? line[LineW-1:PixW] : '0;
    newc[1] = s1_q.has_mid ? line[PixW-1:0] : '0;
    newc[2] = s1_q.pix;
  end

  // Gradient: new right column minus old left column, center row weighted 2
  always_comb begin
    for (int r = 0; r < KSize; r++) begin
      if (s1_q.col_first) begin
        diff[r] = GradW'(0) - $signed(GradW'(c1_q[r]));
      end else begin
        diff[r] = $signed(GradW'(newc[r])) - $signed(GradW'(c1_q[r]));
      end
    end
    grad = diff[0] + (diff[1] <<< 1) + diff[2];
  end

  // Line RAM write-back: upper takes the middle row, middle takes the new pixel
  assign we_o    = proc;
  assign waddr_o = s1_q.col;
  assign wdata_o = {newc[1], newc[2]};

  assign push_o     = proc && s1_q.emit;
  assign res_o.grad = grad;
  assign res_o.last = s1_q.frame_end;

  // Request register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q <= item_i;
    end
  end

  // Valid, forwarding and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fw_vld_q  <= 1'b0;
      fw_addr_q <= '0;
      fw_data_q <= '0;
      for (int r = 0; r < KSize; r++) begin
        c1_q[r] <= '0;
        c2_q[r] <= '0;
      end
    end else begin
      s1_vld_q <= load_i || (s1_vld_q && !adv_o);
      if (proc) begin
        fw_vld_q  <= 1'b1;
        fw_addr_q <= s1_q.col;
        fw_data_q <= {newc[1], newc[2]};
        for (int r = 0; r < KSize; r++) begin
          if (s1_q.frame_end) begin
            c1_q[r] <= '0;
            c2_q[r] <= '0;
          end else if (s1_q.col_first) begin
            c1_q[r] <= '0;
            c2_q[r] <= newc[r];
          end else begin
            c1_q[r] <= c2_q[r];
            c2_q[r] <= newc[r];
          end
        end
      end
    end
  end

endmodule

// ===== hdl/sxc_out.sv =====
// Output buffer: result register plus one skid entry on the master side.
// Depends on sxc_pkg.
`timescale 1ns / 1ps

module sxc_out (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  sxc_pkg::sxc_res_t            res_i,
  output logic                         ready_o,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [sxc_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast
);
  import sxc_pkg::*;

  sxc_res_t out_q, skid_q;
  logic     out_vld_q, skid_vld_q;
  logic     pop, out_free;

  assign pop      = out_vld_q && m_axis_tready;
  assign out_free = !out_vld_q || pop;
  assign ready_o  = !skid_vld_q;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutDataW'(out_q.grad);
  assign m_axis_tlast  = out_q.last;

  // Payload: skid drains first, a new result parks in skid when blocked
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : res_i;
    end
    if (!skid_vld_q && push_i && !out_free) begin
      skid_q <= res_i;
    end
  end

  // Occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_vld_q <= skid_vld_q || push_i;
      end
      if (skid_vld_q) begin
        skid_vld_q <= !out_free;
      end else begin
        skid_vld_q <= push_i && !out_free;
      end
    end
  end

endmodule

// ===== hdl/sobel_x_convolution_stream_unit.sv =====
// Sobel-x gradient over a raster pixel stream, zero padding on every border.
// Slave side: tdata = pixel, tuser = command (pixel or drain request).
// Master side: tdata = gradient (11-bit two's complement), tlast = frame end.
// The result for pixel n of a frame leaves with input request n + width + 1,
// so width + 1 drain requests follow the last pixel of each frame.
// A result passes the window-stage request register and then the output register
// before it is valid on the master side; one request per cycle unless stalled.
// Both rows above the current one live in a single line RAM (16 bits wide,
// one read and one write per cycle); the window update is the only loop.
// Reset clears counters, window and output buffer; the line RAM needs no
// clearing since rows not yet filled in the frame are masked to zero.
// The user must write width and height via the cfg port while idle; not enforced.
// When the receiver stalls, a result register plus a skid entry absorb the
// pipeline; tready drops only when a result cannot be parked.
// Depends on sxc_pkg, sxc_ctrl, sxc_win, sxc_out and sxc_ram.
`timescale 1ns / 1ps

module sobel_x_convolution_stream_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [sxc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sxc_pkg::CfgW-1:0]     cfg_wdata_i,
  // slave stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [sxc_pkg::InDataW-1:0]  s_axis_tdata,   // [7:0] pixel
  input  logic                         s_axis_tuser,   // [0] command
  // master stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [sxc_pkg::OutDataW-1:0] m_axis_tdata,   // [10:0] gradient
  output logic                         m_axis_tlast
);
  import sxc_pkg::*;

  logic             accept, adv, out_ready, push;
  logic             we;
  logic [ColW-1:0]  raddr, waddr;
  logic [LineW-1:0] rdata, wdata;
  sxc_item_t        item;
  sxc_res_t         res;

  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  sxc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .command_i   (s_axis_tuser),
    .pixel_i     (s_axis_tdata[PixW-1:0]),
    .rd_addr_o   (raddr),
    .item_o      (item)
  );

  // Upper line in the high byte, middle line in the low byte
  sxc_ram #(
    .Width (LineW),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  sxc_win u_win (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .item_i      (item),
    .out_ready_i (out_ready),
    .adv_o       (adv),
    .rdata_i     (rdata),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .push_o      (push),
    .res_o       (res)
  );

  sxc_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .res_i         (res),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== hdl/sxc_chk.sv =====
// Port-level checker for the Sobel-x stream unit, bound to the top level.
// Depends on sxc_pkg and sobel_x_convolution_stream_unit_defines.svh.
`timescale 1ns / 1ps
`include "sobel_x_convolution_stream_unit_defines.svh"

module sxc_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [sxc_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                         m_axis_tlast
);
  import sxc_pkg::*;

  // A stalled result keeps its payload
  `SXC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

  // Last pixel of a frame sits on the right border, so its gradient is not positive
  `SXC_ASSERT_IMPL(a_last_sign, m_axis_tvalid && m_axis_tlast, m_axis_tdata[GradW-1] || (m_axis_tdata[GradW-1:0] == '0), "positive gradient at frame end")

  // Leaving reset: empty pipeline, input open
  `SXC_ASSERT_IMPL(a_reset_exit, $past(!rst_ni), s_axis_tready && !m_axis_tvalid, "bad state after reset")

endmodule

bind sobel_x_convolution_stream_unit sxc_chk u_sxc_chk (.*);
